/* rtl/serial_command_frame_parser_top_assert.svh */
// Assertion macros shared by the frame parser modules.
`ifndef SERIAL_COMMAND_FRAME_PARSER_TOP_ASSERT_SVH
`define SERIAL_COMMAND_FRAME_PARSER_TOP_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, checked outside reset.
`define SCFP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, checked outside reset.
`define SCFP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SCFP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define SCFP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* rtl/scfp_pkg.sv */
// Types and constants shared by the frame parser modules.
package scfp_pkg;

	localparam logic [7:0] START_BYTE  = 8'h4D;
	localparam logic [7:0] END_BYTE    = 8'h45;
	localparam logic [7:0] ASCII_PLUS  = 8'h2B;
	localparam logic [7:0] ASCII_MINUS = 8'h2D;

	localparam logic signed [11:0] CHECK_MOD = 12'sd1000;

	// Position of the next byte within a frame.
	localparam logic [3:0] POS_IDLE     = 4'd0;
	localparam logic [3:0] POS_CODE_C0  = 4'd2;
	localparam logic [3:0] POS_CODE_C1  = 4'd3;
	localparam logic [3:0] POS_CODE_C2  = 4'd4;
	localparam logic [3:0] POS_VALUE_C0 = 4'd6;
	localparam logic [3:0] POS_VALUE_C1 = 4'd7;
	localparam logic [3:0] POS_VALUE_C2 = 4'd8;
	localparam logic [3:0] POS_CHECK_C0 = 4'd10;
	localparam logic [3:0] POS_CHECK_C1 = 4'd11;
	localparam logic [3:0] POS_CHECK_C2 = 4'd12;
	localparam logic [3:0] POS_END      = 4'd14;

	typedef enum logic [1:0] {
		FIELD_CODE  = 2'd0,
		FIELD_VALUE = 2'd1,
		FIELD_CHECK = 2'd2
	} field_sel_t;

	// Work item from the front end: a finished field or the end byte.
	typedef struct packed {
		logic       is_end;
		field_sel_t sel;
		logic [23:0] chars;
	} cmd_t;

	typedef struct packed {
		logic signed [10:0] command_code;
		logic signed [10:0] command_value;
		logic               frame_ok;
	} res_t;

	localparam int CMD_W = $bits(cmd_t);
	localparam int RES_W = $bits(res_t);

endpackage

/* rtl/scfp_fifo.sv */
// Small register queue with first-word fall-through read.
module scfp_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);
`include "serial_command_frame_parser_top_assert.svh"

	// Pointers wrap at the last entry, so any depth works.
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`SCFP_ASSERT_IMP(a_fifo_bound, clk, arst_n, 1'b1, count_q <= CW'(DEPTH), "queue overfilled")

endmodule

/* rtl/scfp_front.sv */
// Front end: track frame position, gather field characters, emit work items.
module scfp_front import scfp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic [7:0] rx_byte,
	output logic       full,
	input  logic       cmd_full,
	output logic       cmd_push,
	output cmd_t       cmd_item
);
`include "serial_command_frame_parser_top_assert.svh"

	logic [3:0]  pos_q;
	logic [15:0] chars_q;
	logic [3:0]  pos_d;
	logic [15:0] chars_d;
	logic        emits;
	logic        acc;

	// Only the last character of a field and the end byte need queue room.
	assign emits = (pos_q == POS_CODE_C2) || (pos_q == POS_VALUE_C2) ||
	               (pos_q == POS_CHECK_C2) || (pos_q == POS_END);
	assign full     = cmd_full && emits;
	assign acc      = push && !full;
	assign cmd_push = acc && emits;

	always_comb begin
		pos_d          = pos_q + 1'b1;
		chars_d        = chars_q;
		cmd_item.is_end = 1'b0;
		cmd_item.sel    = FIELD_CODE;
		cmd_item.chars  = {rx_byte, chars_q};
		unique case (pos_q) inside
			POS_IDLE: begin
				pos_d = (rx_byte == START_BYTE) ? 4'(POS_IDLE + 4'd1) : POS_IDLE;
			end
			POS_CODE_C0, POS_VALUE_C0, POS_CHECK_C0: begin
				chars_d[7:0] = rx_byte;
			end
			POS_CODE_C1, POS_VALUE_C1, POS_CHECK_C1: begin
				chars_d[15:8] = rx_byte;
			end
			POS_CODE_C2: begin
				cmd_item.sel = FIELD_CODE;
			end
			POS_VALUE_C2: begin
				cmd_item.sel = FIELD_VALUE;
			end
			POS_CHECK_C2: begin
				cmd_item.sel = FIELD_CHECK;
			end
			POS_END: begin
				cmd_item.is_end = 1'b1;
				cmd_item.chars  = {16'd0, rx_byte};
				pos_d           = POS_IDLE;
			end
			default: begin
				// separators: advance without looking at the byte
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= POS_IDLE;
			chars_q <= '0;
		end else if (acc) begin
			pos_q   <= pos_d;
			chars_q <= chars_d;
		end
	end

	`SCFP_ASSERT_NXT(a_idle_drop, clk, arst_n,
		acc && pos_q == POS_IDLE && rx_byte != START_BYTE, pos_q == POS_IDLE,
		"non-start byte left idle")

endmodule

/* rtl/scfp_back.sv */
// Back end: convert fields, check the frame and build the result.
module scfp_back import scfp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_empty,
	input  cmd_t cmd_head,
	output logic cmd_pop,
	input  logic res_full,
	output logic res_push,
	output res_t res_item
);
`include "serial_command_frame_parser_top_assert.svh"

	logic signed [10:0] code_q;
	logic signed [10:0] value_q;
	logic signed [10:0] check_q;
	logic signed [10:0] field_val;
	logic signed [11:0] sum;
	logic signed [11:0] sum_mod;
	logic               ok;

	// atoi over three characters, lowest byte first.
	function automatic logic signed [10:0] atoi3(input logic [23:0] chars);
		logic [7:0]  c;
		logic [9:0]  acc;
		logic [13:0] prod;
		logic        lead;
		logic        live;
		logic        neg;
		logic        is_digit;
		logic        is_space;
		acc  = '0;
		lead = 1'b1;
		live = 1'b0;
		neg  = 1'b0;
		for (int k = 0; k < 3; k++) begin
			c        = chars[8*k +: 8];
			is_digit = (c >= 8'h30) && (c <= 8'h39);
			is_space = (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
			prod     = 14'(acc) * 14'd10 + 14'(c[3:0]);
			if (lead) begin
				if (!is_space) begin
					lead = 1'b0;
					if ((c == ASCII_PLUS) || (c == ASCII_MINUS)) begin
						live = 1'b1;
						neg  = (c == ASCII_MINUS);
					end else if (is_digit) begin
						live = 1'b1;
						acc  = 10'(prod);
					end else begin
						live = 1'b0;
					end
				end
			end else if (live && is_digit) begin
				acc = 10'(prod);
			end else begin
				live = 1'b0;
			end
		end
		return neg ? -$signed({1'b0, acc}) : $signed({1'b0, acc});
	endfunction

	assign field_val = atoi3(cmd_head.chars);

	// Truncating modulo: the sum never reaches -1000 and stays below 2000.
	assign sum     = {code_q[10], code_q} + {value_q[10], value_q};
	assign sum_mod = (sum >= CHECK_MOD) ? sum - CHECK_MOD : sum;
	assign ok      = (cmd_head.chars[7:0] == END_BYTE) && ({check_q[10], check_q} == sum_mod);

	// Hold an end item until the result queue has room.
	assign cmd_pop  = !cmd_empty && (!cmd_head.is_end || !res_full);
	assign res_push = cmd_pop && cmd_head.is_end;

	assign res_item.command_code  = ok ? code_q : '0;
	assign res_item.command_value = ok ? value_q : '0;
	assign res_item.frame_ok      = ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_q  <= '0;
			value_q <= '0;
			check_q <= '0;
		end else if (cmd_pop && !cmd_head.is_end) begin
			unique case (cmd_head.sel)
				FIELD_CODE:  code_q  <= field_val;
				FIELD_VALUE: value_q <= field_val;
				FIELD_CHECK: check_q <= field_val;
				default: begin
				end
			endcase
		end
	end

	`SCFP_ASSERT_IMP(a_res_from_end, clk, arst_n, res_push, !cmd_empty && cmd_head.is_end,
		"result pushed without an end item")

endmodule

/* rtl/serial_command_frame_parser_top.sv */
// Top level of the serial command frame parser.
//
// Input side is a queue write port: present a received byte on rx_byte with
// push high; the beat is taken at a rising edge where full is low. Bytes
// outside a frame are dropped until 'M'; a frame is M, separator, three
// fields of three characters each followed by a separator, and an end byte.
// Output side is a queue read port: while empty is low the oldest result
// (command_code, command_value, frame_ok) is on the ports; pop takes it.
// Throughput: one byte per cycle sustained; full only rises on a byte that
// ends a field or the frame while the internal work queue is full.
// After its end byte is taken, the end item is written into the work queue;
// the back end builds the result from the queue head and writes it into the
// result queue, where it shows on the ports once older results are popped.
// If the receiver stalls, results gather in the result queue, then end items
// wait in the work queue, and finally full stops new field-ending bytes.
// Reset clears both queues and returns the parser to waiting for 'M'.
module serial_command_frame_parser_top import scfp_pkg::*; #(
	parameter int CMD_DEPTH = 2,
	parameter int RES_DEPTH = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [7:0]        rx_byte,
	output logic              full,
	input  logic              pop,
	output logic              empty,
	output logic signed [10:0] command_code,
	output logic signed [10:0] command_value,
	output logic              frame_ok
);

	logic             cmd_full;
	logic             cmd_push;
	cmd_t             cmd_item;
	logic             cmd_empty;
	logic             cmd_pop;
	logic [CMD_W-1:0] cmd_rd;
	logic             res_full;
	logic             res_push;
	res_t             res_item;
	logic [RES_W-1:0] res_rd;
	res_t             res_out;

	// Front end: position tracking and character gathering.
	scfp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.rx_byte  (rx_byte),
		.full     (full),
		.cmd_full (cmd_full),
		.cmd_push (cmd_push),
		.cmd_item (cmd_item)
	);

	// Work queue decouples byte intake from conversion.
	scfp_fifo #(.WIDTH(CMD_W), .DEPTH(CMD_DEPTH)) u_cmd_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_data (cmd_item),
		.full    (cmd_full),
		.rd_en   (cmd_pop),
		.rd_data (cmd_rd),
		.empty   (cmd_empty)
	);

	// Back end: field conversion, checksum and result build.
	scfp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd_head  (cmd_t'(cmd_rd)),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res_item  (res_item)
	);

	// Result queue: holds finished frames while the receiver stalls.
	scfp_fifo #(.WIDTH(RES_W), .DEPTH(RES_DEPTH)) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_item),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (res_rd),
		.empty   (empty)
	);

	assign res_out       = res_t'(res_rd);
	assign command_code  = res_out.command_code;
	assign command_value = res_out.command_value;
	assign frame_ok      = res_out.frame_ok;

endmodule
